@@ sv/jtag_seq_pkg.sv @@
// ----------------------------------------------------------------------------
// jtag_seq_pkg
// Shared types and constants for the JTAG chain scan sequencer: command
// kinds, TAP controller walk phases, and the structs passed between modules.
// ----------------------------------------------------------------------------
package jtag_seq_pkg;

  // chain limits and word sizes
  localparam int MaxTaps   = 4;
  localparam int IrFields  = 4;
  localparam int TapLim    = (MaxTaps < IrFields) ? MaxTaps : IrFields;
  localparam int DrBits    = 32;
  localparam int DrIdxW    = $clog2(DrBits);
  localparam int IrLenW    = 6;
  localparam int IrLenMax  = 32;

  // configuration register indexes
  localparam logic [1:0] CfgIrLengths = 2'd0;
  localparam logic [1:0] CfgTapCount  = 2'd1;

  // reset values of the configuration registers
  localparam logic [23:0] IrLengthsReset = 24'd266305;
  localparam logic [2:0]  TapCountReset  = 3'd1;

  // command kinds
  localparam logic [1:0] KindTick = 2'd0;
  localparam logic [1:0] KindIr   = 2'd1;
  localparam logic [1:0] KindDr   = 2'd2;

  // walk through the TAP controller states
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEL_DR,
    PH_SEL_IR,
    PH_CAPTURE,
    PH_ENTER,
    PH_SHIFT,
    PH_UPDATE,
    PH_RETURN
  } phase_t;

  // clamped chain description
  typedef struct packed {
    logic [TapLim-1:0][IrLenW-1:0] ir_len;
    logic [2:0]                    taps;
  } chain_cfg_t;

  // one input word
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  tap_index;
    logic [31:0] ir_value;
    logic        tdo_in;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic        tms_out;
    logic        tdi_out;
    logic        last_cycle;
    logic        dr_valid;
    logic [31:0] dr_word;
  } res_t;

endpackage

@@ sv/jtag_seq_cfg.sv @@
// ----------------------------------------------------------------------------
// jtag_seq_cfg
// Configuration registers for the chain: packed IR lengths and TAP count,
// presented to the sequencer already clamped to their legal ranges.
// ----------------------------------------------------------------------------
module jtag_seq_cfg
  import jtag_seq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output chain_cfg_t  chain
);

  logic [23:0] chain_ir_lengths;
  logic [2:0]  tap_count;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_ir_lengths <= IrLengthsReset;
      tap_count        <= TapCountReset;
    end else if (cfg_valid) begin
      if (cfg_index == CfgIrLengths) chain_ir_lengths <= cfg_data;
      if (cfg_index == CfgTapCount)  tap_count        <= cfg_data[2:0];
    end
  end

  // clamp each length to 1..32 and the count to 1..limit
  always_comb begin
    logic [IrLenW-1:0] raw;
    for (int t = 0; t < TapLim; t++) begin
      raw = chain_ir_lengths[t*IrLenW +: IrLenW];
      if (raw == '0)                             chain.ir_len[t] = IrLenW'(1);
      else if (raw > IrLenW'(IrLenMax))          chain.ir_len[t] = IrLenW'(IrLenMax);
      else                                       chain.ir_len[t] = raw;
    end
    if (tap_count == 3'd0)              chain.taps = 3'd1;
    else if (tap_count > 3'(TapLim))    chain.taps = 3'(TapLim);
    else                                chain.taps = tap_count;
  end

endmodule

@@ sv/jtag_seq_core.sv @@
// ----------------------------------------------------------------------------
// jtag_seq_core
// Scan state and the per-word step: starts IR scans and DR reads from idle,
// and for each tick produces TMS/TDI, captures TDO and finishes the scan.
// ----------------------------------------------------------------------------
module jtag_seq_core
  import jtag_seq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cmd_t       cmd,
  input  chain_cfg_t chain,
  output logic       produce,
  output res_t       res
);

  phase_t      scan_phase, scan_phase_next;
  logic        scan_is_read, scan_is_read_next;
  logic [6:0]  bit_count, bit_count_next;
  logic [6:0]  bits_before, bits_before_next;
  logic [6:0]  bits_after, bits_after_next;
  logic [5:0]  chosen_ir_length, chosen_ir_length_next;
  logic [31:0] ir_shift, ir_shift_next;
  logic [31:0] dr_shift, dr_shift_next;

  logic [7:0]  sum_before;
  logic [7:0]  sum_after;
  logic [5:0]  sel_len;
  logic        target_ok;

  // IR bits ahead of and behind the chosen TAP
  always_comb begin
    sum_before = '0;
    sum_after  = '0;
    sel_len    = chain.ir_len[cmd.tap_index];
    for (int t = 0; t < TapLim; t++) begin
      if (t < int'(cmd.tap_index)) sum_before = sum_before + 8'(chain.ir_len[t]);
      if (t > int'(cmd.tap_index) && t < int'(chain.taps))
        sum_after = sum_after + 8'(chain.ir_len[t]);
    end
    target_ok = ({1'b0, cmd.tap_index} < chain.taps);
  end

  // next state and result
  always_comb begin
    logic [7:0] p8, lo, hi, total, body, q8;
    scan_phase_next       = scan_phase;
    scan_is_read_next     = scan_is_read;
    bit_count_next        = bit_count;
    bits_before_next      = bits_before;
    bits_after_next       = bits_after;
    chosen_ir_length_next = chosen_ir_length;
    ir_shift_next         = ir_shift;
    dr_shift_next         = dr_shift;
    produce               = 1'b0;
    res                   = '{tms_out: 1'b0, tdi_out: 1'b1, last_cycle: 1'b0,
                              dr_valid: 1'b0, dr_word: '0};

    p8    = {1'b0, bit_count};
    body  = scan_is_read ? 8'(DrBits) : 8'(chosen_ir_length);
    lo    = {1'b0, bits_before};
    hi    = lo + body;
    total = hi + {1'b0, bits_after};
    q8    = p8 - lo;

    if (step) begin
      if (scan_phase == PH_IDLE) begin
        // start command arms a scan
        if ((cmd.kind == KindIr || cmd.kind == KindDr) && target_ok) begin
          scan_is_read_next = (cmd.kind == KindDr);
          bit_count_next    = '0;
          dr_shift_next     = '0;
          ir_shift_next     = cmd.ir_value;
          if (cmd.kind == KindDr) begin
            bits_before_next      = 7'(cmd.tap_index);
            bits_after_next       = '0;
            chosen_ir_length_next = '0;
          end else begin
            bits_before_next      = sum_before[6:0];
            bits_after_next       = sum_after[6:0];
            chosen_ir_length_next = sel_len;
          end
          scan_phase_next = PH_SEL_DR;
        end
      end else if (cmd.kind == KindTick) begin
        produce = 1'b1;
        case (scan_phase)
          PH_SEL_DR: begin
            res.tms_out     = 1'b1;
            scan_phase_next = scan_is_read ? PH_CAPTURE : PH_SEL_IR;
          end
          PH_SEL_IR: begin
            res.tms_out     = 1'b1;
            scan_phase_next = PH_CAPTURE;
          end
          PH_CAPTURE: begin
            scan_phase_next = PH_ENTER;
          end
          PH_ENTER: begin
            bit_count_next  = '0;
            scan_phase_next = PH_SHIFT;
          end
          PH_SHIFT: begin
            // data window of the chosen TAP
            if (p8 >= lo && p8 < hi) begin
              if (scan_is_read) begin
                if (cmd.tdo_in) dr_shift_next[q8[DrIdxW-1:0]] = 1'b1;
              end else begin
                res.tdi_out   = ir_shift[0];
                ir_shift_next = {1'b0, ir_shift[31:1]};
              end
            end
            if (p8 + 8'd1 >= total) begin
              res.tms_out     = 1'b1;
              scan_phase_next = PH_UPDATE;
            end else begin
              bit_count_next = bit_count + 7'd1;
            end
          end
          PH_UPDATE: begin
            res.tms_out     = 1'b1;
            scan_phase_next = PH_RETURN;
          end
          default: begin
            res.last_cycle = 1'b1;
            if (scan_is_read) begin
              res.dr_valid = 1'b1;
              res.dr_word  = dr_shift;
            end
            scan_phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase       <= PH_IDLE;
      scan_is_read     <= 1'b0;
      bit_count        <= '0;
      bits_before      <= '0;
      bits_after       <= '0;
      chosen_ir_length <= '0;
      ir_shift         <= '0;
      dr_shift         <= '0;
    end else begin
      scan_phase       <= scan_phase_next;
      scan_is_read     <= scan_is_read_next;
      bit_count        <= bit_count_next;
      bits_before      <= bits_before_next;
      bits_after       <= bits_after_next;
      chosen_ir_length <= chosen_ir_length_next;
      ir_shift         <= ir_shift_next;
      dr_shift         <= dr_shift_next;
    end
  end

endmodule

@@ sv/jtag_chain_scan_sequencer.sv @@
// ----------------------------------------------------------------------------
// jtag_chain_scan_sequencer
// JTAG scan engine for a daisy chain of up to four TAPs: IR scans into one
// chosen TAP and 32-bit DR reads, with a TMS/TDI result for each tick word.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/ready     kind, tap_index, ir_value, tdo_in
//   out      output     out_valid/ready    tms_out, tdi_out, last_cycle,
//                                          dr_valid, dr_word
//   cfg      input      cfg_valid/ready    cfg_index, cfg_data
//
// Each word is held in the input register, is stepped against the scan state
// from there and its result lands in the output register; one word per cycle
// is sustained while the output register is free or being drained. The scan
// state update is the only loop. A held output stalls stepping; the input
// register still takes one word. cfg is always ready. Synchronous reset puts
// the engine in Run-Test/Idle.
// ----------------------------------------------------------------------------
module jtag_chain_scan_sequencer
  import jtag_seq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command and tick words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [1:0]  tap_index,
  input  logic [31:0] ir_value,
  input  logic        tdo_in,
  // per-cycle results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tms_out,
  output logic        tdi_out,
  output logic        last_cycle,
  output logic        dr_valid,
  output logic [31:0] dr_word,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  chain_cfg_t chain;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       step;
  logic       produce;
  res_t       res_comb;
  res_t       res;

  jtag_seq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chain     (chain)
  );

  // step when the output register is free or being drained
  assign step     = cmd_valid && (!out_valid || out_ready);
  assign in_ready = !cmd_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd <= '{kind: kind, tap_index: tap_index, ir_value: ir_value, tdo_in: tdo_in};
    end
  end

  jtag_seq_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .cmd     (cmd),
    .chain   (chain),
    .produce (produce),
    .res     (res_comb)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= produce;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      res <= res_comb;
    end
  end

  assign tms_out    = res.tms_out;
  assign tdi_out    = res.tdi_out;
  assign last_cycle = res.last_cycle;
  assign dr_valid   = res.dr_valid;
  assign dr_word    = res.dr_word;

endmodule

@@ tb/scan_scoreboard_pkg.sv @@
// ----------------------------------------------------------------------------
// scan_scoreboard_pkg
// Scoreboard for the JTAG chain scan sequencer. It keeps its own copy of the
// chain setup and the scan walk, predicts the TMS/TDI word of every tick, and
// checks each result word from the block against the oldest prediction.
// ----------------------------------------------------------------------------
package scan_scoreboard_pkg;
  import jtag_seq_pkg::*;

  class scan_scoreboard;
    // chain setup as last written
    logic [23:0] ir_lengths;
    logic [2:0]  tap_cfg;
    // scan walk state
    phase_t      phase;
    bit          is_read;
    int unsigned bit_pos;
    int unsigned lead_bits;
    int unsigned tail_bits;
    int unsigned target_len;
    logic [31:0] ir_bits;
    logic [31:0] captured;
    // predicted tick words, oldest first
    res_t        expected_ticks[$];
    // command channel words taken by the block
    int unsigned accepted;
    int unsigned errors;

    function new();
      ir_lengths = IrLengthsReset;
      tap_cfg    = TapCountReset;
      phase      = PH_IDLE;
      is_read    = 1'b0;
      bit_pos    = 0;
      lead_bits  = 0;
      tail_bits  = 0;
      target_len = 0;
      ir_bits    = '0;
      captured   = '0;
      accepted   = 0;
      errors     = 0;
    endfunction

    // ir length of one tap, held to 1..32
    function int unsigned tap_len(int unsigned t);
      int unsigned v;
      v = 32'(ir_lengths[6*t +: 6]);
      if (v < 1) v = 1;
      if (v > IrLenMax) v = IrLenMax;
      return v;
    endfunction

    // taps in the chain, held to 1..TapLim
    function int unsigned chain_taps();
      int unsigned c;
      c = 32'(tap_cfg);
      if (c < 1) c = 1;
      if (c > TapLim) c = TapLim;
      return c;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [23:0] data);
      if (idx == CfgIrLengths) ir_lengths = data;
      else if (idx == CfgTapCount) tap_cfg = data[2:0];
    endfunction

    function bit scanning();
      return phase != PH_IDLE;
    endfunction

    function int unsigned pending();
      return expected_ticks.size();
    endfunction

    // advance the walk by one accepted word and queue its tick word, if any
    function void step_word(logic [1:0] k, logic [1:0] idx, logic [31:0] irv, logic tdo);
      res_t        r;
      int unsigned cnt;
      int unsigned body;
      int unsigned total;
      int unsigned q;
      accepted++;
      r.tms_out    = 1'b0;
      r.tdi_out    = 1'b1;
      r.last_cycle = 1'b0;
      r.dr_valid   = 1'b0;
      r.dr_word    = '0;
      // in run-test/idle only a start in range does anything
      if (phase == PH_IDLE) begin
        if (k == KindIr || k == KindDr) begin
          cnt = chain_taps();
          if (32'(idx) < cnt) begin
            is_read  = (k == KindDr);
            bit_pos  = 0;
            captured = '0;
            ir_bits  = irv;
            lead_bits  = 0;
            tail_bits  = 0;
            target_len = 0;
            if (is_read) begin
              lead_bits = 32'(idx);
            end else begin
              for (int t = 0; t < 32'(idx); t++) lead_bits += tap_len(t);
              for (int t = 32'(idx) + 1; t < cnt; t++) tail_bits += tap_len(t);
              target_len = tap_len(32'(idx));
            end
            phase = PH_SEL_DR;
          end
        end
        return;
      end
      // starts and spare kinds are dropped while a scan runs
      if (k != KindTick) return;
      case (phase)
        PH_SEL_DR: begin
          r.tms_out = 1'b1;
          phase = is_read ? PH_CAPTURE : PH_SEL_IR;
        end
        PH_SEL_IR: begin
          r.tms_out = 1'b1;
          phase = PH_CAPTURE;
        end
        PH_CAPTURE: phase = PH_ENTER;
        PH_ENTER: begin
          bit_pos = 0;
          phase = PH_SHIFT;
        end
        PH_SHIFT: begin
          body  = is_read ? DrBits : target_len;
          total = lead_bits + body + tail_bits;
          // bypass and neighbor ir bits keep tdi high
          if (bit_pos >= lead_bits && bit_pos < lead_bits + body) begin
            q = bit_pos - lead_bits;
            if (is_read) begin
              if (q < 32 && tdo === 1'b1) captured[q] = 1'b1;
            end else begin
              r.tdi_out = ir_bits[0];
              ir_bits = ir_bits >> 1;
            end
          end
          if (bit_pos + 1 >= total) begin
            r.tms_out = 1'b1;
            phase = PH_UPDATE;
          end else begin
            bit_pos++;
          end
        end
        PH_UPDATE: begin
          r.tms_out = 1'b1;
          phase = PH_RETURN;
        end
        default: begin
          r.last_cycle = 1'b1;
          if (is_read) begin
            r.dr_valid = 1'b1;
            r.dr_word  = captured;
          end
          phase = PH_IDLE;
        end
      endcase
      expected_ticks.push_back(r);
    endfunction

    function void field_error(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    // compare one result word against the oldest prediction
    function void check_result(logic tms, logic tdi, logic last, logic valid,
                               logic [31:0] word);
      res_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result word with nothing expected: tms %b tdi %b last %b valid %b word %h",
                   tms, tdi, last, valid, word);
        return;
      end
      want = expected_ticks.pop_front();
      if (tms !== want.tms_out) field_error("tms_out", 32'(want.tms_out), 32'(tms));
      if (tdi !== want.tdi_out) field_error("tdi_out", 32'(want.tdi_out), 32'(tdi));
      if (last !== want.last_cycle)
        field_error("last_cycle", 32'(want.last_cycle), 32'(last));
      if (valid !== want.dr_valid) field_error("dr_valid", 32'(want.dr_valid), 32'(valid));
      if (word !== want.dr_word) field_error("dr_word", want.dr_word, word);
    endfunction

    // predictions never matched by a result word
    function void leftover_check();
      if (expected_ticks.size() != 0) begin
        errors += expected_ticks.size();
        $display("%0d expected result words never arrived", expected_ticks.size());
      end
    endfunction
  endclass

endpackage

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for jtag_chain_scan_sequencer. Runs directed IR scans and DR reads
// across clamped chain setups, then random scans with stray words mixed in,
// with random idling on both channels. Every tick word is checked field by
// field against the scoreboard's own model of the scan walk.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jtag_seq_pkg::*;
  import scan_scoreboard_pkg::*;

  localparam logic [1:0] KindSpare   = 2'd3;
  localparam logic [1:0] CfgSpareLo  = 2'd2;
  localparam logic [1:0] CfgSpareHi  = 2'd3;
  localparam int         TdoLow      = 0;
  localparam int         TdoHigh     = 1;
  localparam int         TdoRandom   = 2;
  localparam int unsigned ItemTarget = 1100;
  localparam int unsigned CycleLimit = 500000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [1:0]  tap_index;
  logic [31:0] ir_value;
  logic        tdo_in;
  logic        out_valid;
  logic        out_ready;
  logic        tms_out;
  logic        tdi_out;
  logic        last_cycle;
  logic        dr_valid;
  logic [31:0] dr_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  scan_scoreboard sb;
  bit             steady = 1'b0;
  int unsigned    cycles = 0;

  jtag_chain_scan_sequencer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .tap_index  (tap_index),
    .ir_value   (ir_value),
    .tdo_in     (tdo_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tms_out    (tms_out),
    .tdi_out    (tdi_out),
    .last_cycle (last_cycle),
    .dr_valid   (dr_valid),
    .dr_word    (dr_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("jtag_chain_scan_sequencer verification failed");
      $finish;
    end
  end

  // check every result word taken
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready)
      sb.check_result(tms_out, tdi_out, last_cycle, dr_valid, dr_word);
  end

  function automatic int pick_gap();
    return steady ? 0 : $urandom_range(0, 19);
  endfunction

  // result side: random stall before taking each word
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  // one word on the command channel, called and left at a falling edge
  task automatic send_word(logic [1:0] k, logic [1:0] idx, logic [31:0] irv, logic tdo);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind      = k;
    tap_index = idx;
    ir_value  = irv;
    tdo_in    = tdo;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.step_word(k, idx, irv, tdo);
    @(negedge clk);
  endtask

  // start or spare word, dropped when a scan is running
  task automatic send_stray();
    send_word(2'($urandom_range(1, 3)), 2'($urandom_range(0, 3)), $urandom,
              1'($urandom_range(0, 1)));
  endtask

  // start a scan and tick it back to idle, with strays at noise_pct percent
  task automatic run_scan(logic [1:0] k, logic [1:0] idx, logic [31:0] irv,
                          int tdo_mode, int noise_pct);
    logic tdo;
    send_word(k, idx, irv, 1'($urandom_range(0, 1)));
    while (sb.scanning()) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_stray();
      end else begin
        if (tdo_mode == TdoRandom) tdo = 1'($urandom_range(0, 1));
        else tdo = (tdo_mode == TdoHigh);
        send_word(KindTick, 2'($urandom_range(0, 3)), $urandom, tdo);
      end
    end
  endtask

  // hold the command channel until every expected word is back
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_chain(logic [23:0] lengths, logic [2:0] taps);
    drain();
    write_reg(CfgIrLengths, lengths);
    write_reg(CfgTapCount, {21'd0, taps});
  endtask

  // mostly short ir lengths, some zero, some past the top
  function automatic logic [23:0] pick_lengths();
    logic [23:0] v;
    int unsigned sel;
    for (int t = 0; t < 4; t++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) v[6*t +: 6] = 6'd0;
      else if (sel == 1) v[6*t +: 6] = 6'($urandom_range(32, 63));
      else if (sel == 2) v[6*t +: 6] = 6'($urandom_range(9, 31));
      else v[6*t +: 6] = 6'($urandom_range(1, 8));
    end
    return v;
  endfunction

  function automatic logic [31:0] pick_ir();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // stimulus
  initial begin
    int unsigned pick;
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    kind      = KindTick;
    tap_index = '0;
    ir_value  = '0;
    tdo_in    = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CfgIrLengths;
    cfg_data  = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // idle words: tick, spare kind, starts beyond a one-tap chain
    send_word(KindTick, 2'd0, 32'h0, 1'b1);
    send_word(KindSpare, 2'd3, 32'hFFFF_FFFF, 1'b1);
    send_word(KindIr, 2'd1, 32'hFFFF_FFFF, 1'b0);
    send_word(KindDr, 2'd3, 32'h0, 1'b1);
    // reset chain: one tap, ir length 1
    run_scan(KindIr, 2'd0, 32'hFFFF_FFFF, TdoRandom, 0);
    run_scan(KindDr, 2'd0, 32'h0, TdoHigh, 0);
    run_scan(KindIr, 2'd0, 32'h0, TdoLow, 30);
    // all lengths zero and tap count zero clamp up
    set_chain(24'h000000, 3'd0);
    run_scan(KindIr, 2'd0, 32'h5555_5555, TdoRandom, 0);
    run_scan(KindDr, 2'd1, 32'h0, TdoRandom, 0);
    // all lengths 63 clamp to 32, tap count 7 clamps to four
    set_chain(24'hFFFFFF, 3'd7);
    run_scan(KindIr, 2'd0, 32'hA5A5_A5A5, TdoRandom, 0);
    run_scan(KindIr, 2'd3, 32'h8000_0001, TdoRandom, 0);
    run_scan(KindDr, 2'd3, 32'h0, TdoHigh, 0);
    run_scan(KindDr, 2'd0, 32'h0, TdoLow, 20);
    // mixed lengths, full chain
    set_chain({6'd32, 6'd1, 6'd20, 6'd7}, 3'd4);
    run_scan(KindIr, 2'd1, 32'h0F0F_0F0F, TdoRandom, 0);
    run_scan(KindIr, 2'd2, 32'hFFFF_FFFF, TdoRandom, 0);
    run_scan(KindDr, 2'd2, 32'h0, TdoRandom, 0);
    // unused register indexes, then a two-tap chain
    drain();
    write_reg(CfgSpareLo, 24'hFFFFFF);
    write_reg(CfgSpareHi, 24'h000000);
    set_chain({6'd3, 6'd2, 6'd5, 6'd4}, 3'd2);
    run_scan(KindIr, 2'd1, 32'h0000_001B, TdoRandom, 0);
    run_scan(KindDr, 2'd2, 32'h0, TdoRandom, 0);
    run_scan(KindDr, 2'd1, 32'h0, TdoRandom, 0);

    // random scans over random chains
    while (sb.accepted < ItemTarget) begin
      if ($urandom_range(0, 7) == 0) begin
        set_chain(pick_lengths(), 3'($urandom_range(0, 7)));
        steady = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45)
        run_scan(KindIr, 2'($urandom_range(0, 3)), pick_ir(), TdoRandom, 4);
      else if (pick < 85)
        run_scan(KindDr, 2'($urandom_range(0, 3)), pick_ir(), TdoRandom, 4);
      else if (pick < 95)
        send_word($urandom_range(0, 1) ? KindTick : KindSpare, 2'($urandom_range(0, 3)),
                  $urandom, 1'($urandom_range(0, 1)));
      else drain();
    end

    // wait out the last words
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    sb.leftover_check();
    if (sb.errors == 0) begin
      $display("jtag_chain_scan_sequencer verification clean");
    end else begin
      $display("jtag_chain_scan_sequencer verification failed");
    end
    $finish;
  end

endmodule

@@ jtag_chain_scan_sequencer.f @@
sv/jtag_seq_pkg.sv
sv/jtag_seq_cfg.sv
sv/jtag_seq_core.sv
sv/jtag_chain_scan_sequencer.sv
tb/scan_scoreboard_pkg.sv
tb/tb.sv
